/* hw/rtl/ktime_pkg.sv */
package ktime_pkg;

    // Buffer geometry
    localparam int DIGIT_COUNT = 6;
    localparam int INDEX_W     = 3;
    localparam int KEY_W       = 8;
    localparam int HOLDOFF_W   = 8;
    localparam int TIME_W      = 7;
    localparam int NIBBLE_W    = 4;
    localparam int ALIGN_W     = DIGIT_COUNT * NIBBLE_W;
    localparam int OUT_W       = 24;

    // Character codes
    localparam logic [KEY_W-1:0] KEY_NONE  = 8'd0;
    localparam logic [KEY_W-1:0] KEY_STAR  = 8'd42;
    localparam logic [KEY_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [KEY_W-1:0] CHAR_NINE = 8'd57;

    // Limits and reset values
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 8'd5;
    localparam logic [INDEX_W-1:0]   INDEX_FULL    = 3'd6;
    localparam logic [TIME_W-1:0]    MAX_HOURS     = 7'd23;
    localparam logic [TIME_W-1:0]    MAX_MIN_SEC   = 7'd59;

    typedef logic [KEY_W-1:0] char_t;
    typedef char_t [DIGIT_COUNT-1:0] char_buf_t;

    // True for the characters '0' to '9'
    function automatic logic char_is_digit(input char_t c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Two BCD digits to binary
    function automatic logic [TIME_W-1:0] bcd_pair(input logic [NIBBLE_W-1:0] tens,
                                                   input logic [NIBBLE_W-1:0] ones);
        logic [TIME_W-1:0] t;
        t = {3'd0, tens};
        return (t << 3) + (t << 1) + {3'd0, ones};
    endfunction

endpackage

/* hw/rtl/keypad_time_entry.sv */
// Keypad time entry. Each request on the slave side is one scan tick with a
// key code (0 for no key); every tick gives exactly one result on the master
// side. One tick is taken per clock cycle while s_axis_tready is high: the
// whole update of the hold-off counter, setup flag, digit index and
// six-character buffer, plus the decoding of the leading digit run into hours,
// minutes and seconds, happens in one pass of logic between the state registers
// and the single result register. The result appears in the cycle after the tick
// is accepted, and s_axis_tready stays high as long as the result register is empty
// or being drained. holdoff_ticks is written via cfg_wen/cfg_wdata (reset value 5).
module keypad_time_entry
    import ktime_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [HOLDOFF_W-1:0] cfg_wdata,    // holdoff_ticks
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [KEY_W-1:0]     s_axis_tdata, // [7:0] key
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] running, [1] load, [8:2] hours, [15:9] minutes, [22:16] seconds,
    // [23] show_digits
    output logic [OUT_W-1:0]     m_axis_tdata
);

    logic [HOLDOFF_W-1:0] holdoff_ticks_reg;
    logic                 in_setup_reg, in_setup_next;
    logic [HOLDOFF_W-1:0] holdoff_count_reg, holdoff_count_next;
    logic [INDEX_W-1:0]   digit_index_reg, digit_index_next;
    char_buf_t            digit_chars_reg, digit_chars_next;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic                 in_accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Hold the hold-off interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_ticks_reg <= HOLDOFF_RESET;
        end
        else if (cfg_wen)
        begin
            holdoff_ticks_reg <= cfg_wdata;
        end
    end

    // Process one tick
    always_comb
    begin
        logic [HOLDOFF_W-1:0]  hc_dec;
        logic                  star_ok;
        logic                  setup_a;
        logic [INDEX_W-1:0]    idx_a;
        logic                  take;
        logic [DIGIT_COUNT:0]  run_ok;
        logic [ALIGN_W-1:0]    packed_digits;
        logic [ALIGN_W-1:0]    aligned;
        logic [INDEX_W-1:0]    run_len;
        logic [TIME_W-1:0]     hours, minutes, seconds;
        logic                  done;

        // Count hold-off down
        hc_dec = (holdoff_count_reg != '0) ? holdoff_count_reg - 1'b1 : holdoff_count_reg;

        // Toggle setup on an unblocked star
        star_ok            = (s_axis_tdata == KEY_STAR) && (hc_dec == '0);
        setup_a            = in_setup_reg ^ star_ok;
        idx_a              = star_ok ? '0 : digit_index_reg;
        holdoff_count_next = star_ok ? holdoff_ticks_reg : hc_dec;
        digit_chars_next   = digit_chars_reg;
        if (star_ok && setup_a)
        begin
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                digit_chars_next[k] = CHAR_ZERO;
            end
        end

        // Store an accepted key in setup
        take = setup_a && (s_axis_tdata != KEY_NONE) && (s_axis_tdata != KEY_STAR)
               && (holdoff_count_next == '0) && (idx_a < INDEX_FULL);
        digit_index_next = idx_a;
        if (take)
        begin
            holdoff_count_next        = holdoff_ticks_reg;
            digit_chars_next[idx_a]   = s_axis_tdata;
            digit_index_next          = idx_a + 1'b1;
        end

        // Find the leading digit run and keep only its digits
        run_ok[0] = 1'b1;
        run_len   = '0;
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            run_ok[k+1] = run_ok[k] && char_is_digit(digit_chars_next[k]);
            packed_digits[ALIGN_W-1-k*NIBBLE_W -: NIBBLE_W] =
                run_ok[k+1] ? digit_chars_next[k][NIBBLE_W-1:0] : '0;
            run_len = run_len + {2'd0, run_ok[k+1]};
        end

        // Right-align the run as HHMMSS
        aligned = packed_digits >> ({2'd0, INDEX_FULL - run_len} * NIBBLE_W);
        hours   = bcd_pair(aligned[23:20], aligned[19:16]);
        minutes = bcd_pair(aligned[15:12], aligned[11:8]);
        seconds = bcd_pair(aligned[7:4], aligned[3:0]);

        // Leave setup after the sixth key, zeroing an invalid time
        done          = setup_a && (digit_index_next >= INDEX_FULL);
        in_setup_next = setup_a && !done;
        if (done && (hours > MAX_HOURS || minutes > MAX_MIN_SEC || seconds > MAX_MIN_SEC))
        begin
            hours   = '0;
            minutes = '0;
            seconds = '0;
        end

        if (setup_a)
        begin
            out_data_next = {(digit_index_next != '0), seconds, minutes, hours, 1'b1, 1'b0};
        end
        else
        begin
            out_data_next = {{(OUT_W-1){1'b0}}, 1'b1};
        end
    end

    // Advance state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_setup_reg      <= 1'b0;
            holdoff_count_reg <= '0;
            digit_index_reg   <= '0;
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                digit_chars_reg[k] <= CHAR_ZERO;
            end
        end
        else if (in_accept)
        begin
            in_setup_reg      <= in_setup_next;
            holdoff_count_reg <= holdoff_count_next;
            digit_index_reg   <= digit_index_next;
            digit_chars_reg   <= digit_chars_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // Digit index never passes the buffer end
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_index_reg <= INDEX_FULL)
        else $error("digit index out of range");

    // Running results carry no time and no load
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[23:1] == '0))
        else $error("running result carries data");

    // With no digit entered yet the time fields are all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1] && !m_axis_tdata[23]) |->
        (m_axis_tdata[22:2] == '0))
        else $error("nonzero time before any digit");

    // Every accepted tick leaves the result register full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("result lost after accepted tick");
`endif

endmodule
